FILE: design/dsa_pkg.sv
// ----------------------------------------------------------------------------
// Descriptor slot allocator package
// Shared sizes, command and status codes, and configuration register indexes.
// ----------------------------------------------------------------------------
package dsa_pkg;

	localparam int DEPTH          = 1024;
	localparam int SENTINEL_INDEX = 0;
	localparam int IDX_W          = 10;
	localparam int CNT_W          = 11;
	localparam int INC_W          = 12;
	localparam int ADDR_W         = 64;
	localparam int PROD_W         = IDX_W + INC_W;
	localparam int CFG_IDX_W      = 2;

	typedef enum logic [1:0] {
		CMD_ALLOC = 2'd0,
		CMD_FREE  = 2'd1,
		CMD_GET   = 2'd2
	} cmd_t;

	typedef enum logic [2:0] {
		ST_OK       = 3'd0,
		ST_FULL     = 3'd1,
		ST_RANGE    = 3'd2,
		ST_NOTALLOC = 3'd3,
		ST_SENTINEL = 3'd4
	} status_t;

	localparam logic [CFG_IDX_W-1:0] REG_CAPACITY   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_HEAP_START = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_INCREMENT  = 2'd2;

	localparam logic [CNT_W-1:0] CAPACITY_RST  = CNT_W'(1024);
	localparam logic [INC_W-1:0] INCREMENT_RST = INC_W'(32);

endpackage

FILE: design/dsa_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module dsa_ram #(
	parameter int WIDTH = 1,
	parameter int DEPTH = 2
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

FILE: design/descriptor_slot_allocator.sv
// ----------------------------------------------------------------------------
// Descriptor slot allocator
// Hands out slot indices from a LIFO free stack or a bump pointer, frees
// them again, and converts indices into 64-bit handles.
// ----------------------------------------------------------------------------
//  Channel  Handshake              Payload
//  req      req_valid / req_stall  command, slot_index
//  rsp      rsp_valid / rsp_stall  result_index, handle, status
//  cfg      cfg_valid / cfg_ready  cfg_index, cfg_data
//
// One item is accepted per cycle while req_stall is low; the decision and the index
// multiply fill stage two, and the handle add fills the output register.
// Both memories are read at the edge that accepts an item, with a one-entry
// bypass for the write made at that same edge.
// Reset clears the free count and valids and sets the untouched pointer past the
// sentinel; no memory clearing is needed: allocated bits at or above it read clear.
// A stalled output backs up stage by stage to req_stall.
// ----------------------------------------------------------------------------
module descriptor_slot_allocator
	import dsa_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 req_valid,
	output logic                 req_stall,
	input  logic [1:0]           command,
	input  logic [IDX_W-1:0]     slot_index,
	output logic                 rsp_valid,
	input  logic                 rsp_stall,
	output logic [IDX_W-1:0]     result_index,
	output logic [ADDR_W-1:0]    handle,
	output logic [2:0]           status,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [ADDR_W-1:0]    cfg_data
);

	// Configuration
	logic [CNT_W-1:0]  capacity_q;
	logic [ADDR_W-1:0] heap_start_q;
	logic [INC_W-1:0]  increment_q;

	// Allocator state
	logic [CNT_W-1:0]  free_count_q;
	logic [CNT_W-1:0]  next_untouched_q;

	// Last memory writes, for the read-during-write bypass
	logic              stk_bv_q;
	logic [IDX_W-1:0]  stk_ba_q;
	logic [IDX_W-1:0]  stk_bd_q;
	logic              alc_bv_q;
	logic [IDX_W-1:0]  alc_ba_q;
	logic              alc_bd_q;

	// Pipeline
	logic              valid_s1;
	logic [1:0]        cmd_s1;
	logic [IDX_W-1:0]  idx_s1;
	logic [IDX_W-1:0]  stk_ra_s1;
	logic              valid_s2;
	logic [IDX_W-1:0]  idx_s2;
	status_t           st_s2;
	logic              hok_s2;
	logic [PROD_W-1:0] prod_s2;
	logic              valid_s3;
	logic [IDX_W-1:0]  idx_s3;
	logic [ADDR_W-1:0] handle_s3;
	status_t           st_s3;

	logic s3_free, s2_free, go_s1, accept;

	logic [CNT_W-1:0]  eff_cap;
	logic [IDX_W-1:0]  stk_rdata, stk_top;
	logic              alc_rdata, abit;
	logic [CNT_W-1:0]  cnt_d, nu_d, cnt_nx, cnt_m1;
	logic [IDX_W-1:0]  res_idx;
	status_t           res_st;
	logic              res_hok;
	logic              stk_we_d, alc_we_d, alc_wd_d;
	logic [IDX_W-1:0]  alc_wa_d;
	logic              stk_we, alc_we;
	logic [IDX_W-1:0]  stk_raddr;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			capacity_q   <= CAPACITY_RST;
			heap_start_q <= '0;
			increment_q  <= INCREMENT_RST;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_CAPACITY:   capacity_q   <= cfg_data[CNT_W-1:0];
				REG_HEAP_START: heap_start_q <= cfg_data;
				REG_INCREMENT:  increment_q  <= cfg_data[INC_W-1:0];
				default: ;
			endcase
		end
	end

	// Flow control
	assign s3_free   = !valid_s3 || !rsp_stall;
	assign s2_free   = !valid_s2 || s3_free;
	assign go_s1     = valid_s1 && s2_free;
	assign req_stall = valid_s1 && !s2_free;
	assign accept    = req_valid && !req_stall;

	assign eff_cap = (capacity_q > CNT_W'(DEPTH)) ? CNT_W'(DEPTH) : capacity_q;

	// Memory data as seen by the item in stage one.
	assign stk_top = (stk_bv_q && stk_ba_q == stk_ra_s1) ? stk_bd_q : stk_rdata;

	// Entries at or above the untouched pointer have never been written.
	always_comb begin
		if ({1'b0, idx_s1} >= next_untouched_q) begin
			abit = 1'b0;
		end else if (alc_bv_q && alc_ba_q == idx_s1) begin
			abit = alc_bd_q;
		end else begin
			abit = alc_rdata;
		end
	end

	// Decision for the item in stage one.
	always_comb begin
		cnt_d    = free_count_q;
		nu_d     = next_untouched_q;
		res_idx  = idx_s1;
		res_st   = ST_RANGE;
		res_hok  = 1'b0;
		stk_we_d = 1'b0;
		alc_we_d = 1'b0;
		alc_wa_d = idx_s1;
		alc_wd_d = 1'b0;
		unique case (cmd_t'(cmd_s1))
			CMD_ALLOC: begin
				if (free_count_q != '0) begin
					cnt_d    = free_count_q - CNT_W'(1);
					res_idx  = stk_top;
					res_st   = ST_OK;
					res_hok  = 1'b1;
				end else if (next_untouched_q < eff_cap) begin
					nu_d     = next_untouched_q + CNT_W'(1);
					res_idx  = next_untouched_q[IDX_W-1:0];
					res_st   = ST_OK;
					res_hok  = 1'b1;
				end else begin
					res_idx  = '0;
					res_st   = ST_FULL;
				end
				alc_we_d = res_hok;
				alc_wa_d = res_idx;
				alc_wd_d = 1'b1;
			end
			CMD_FREE: begin
				if ({1'b0, idx_s1} >= eff_cap) begin
					res_st = ST_RANGE;
				end else if (idx_s1 == IDX_W'(SENTINEL_INDEX)) begin
					res_st = ST_SENTINEL;
				end else if (!abit) begin
					res_st = ST_NOTALLOC;
				end else begin
					res_st   = ST_OK;
					alc_we_d = 1'b1;
					if (free_count_q < CNT_W'(DEPTH)) begin
						stk_we_d = 1'b1;
						cnt_d    = free_count_q + CNT_W'(1);
					end
				end
			end
			CMD_GET: begin
				if ({1'b0, idx_s1} < eff_cap) begin
					res_st  = ST_OK;
					res_hok = 1'b1;
				end
			end
			default: ;
		endcase
	end

	assign stk_we    = go_s1 && stk_we_d;
	assign alc_we    = go_s1 && alc_we_d;
	assign cnt_nx    = go_s1 ? cnt_d : free_count_q;
	assign cnt_m1    = cnt_nx - CNT_W'(1);
	assign stk_raddr = cnt_m1[IDX_W-1:0];

	dsa_ram #(.WIDTH(IDX_W), .DEPTH(DEPTH)) u_stack (
		.clk   (clk),
		.we    (stk_we),
		.waddr (free_count_q[IDX_W-1:0]),
		.wdata (idx_s1),
		.re    (accept),
		.raddr (stk_raddr),
		.rdata (stk_rdata)
	);

	dsa_ram #(.WIDTH(1), .DEPTH(DEPTH)) u_alloc (
		.clk   (clk),
		.we    (alc_we),
		.waddr (alc_wa_d),
		.wdata (alc_wd_d),
		.re    (accept),
		.raddr (slot_index),
		.rdata (alc_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			free_count_q     <= '0;
			next_untouched_q <= CNT_W'(SENTINEL_INDEX + 1);
			stk_bv_q         <= 1'b0;
			alc_bv_q         <= 1'b0;
			valid_s1         <= 1'b0;
			valid_s2         <= 1'b0;
			valid_s3         <= 1'b0;
		end else begin
			if (go_s1) begin
				free_count_q     <= cnt_d;
				next_untouched_q <= nu_d;
			end
			if (stk_we) begin
				stk_bv_q <= 1'b1;
			end
			if (alc_we) begin
				alc_bv_q <= 1'b1;
			end
			if (accept) begin
				valid_s1 <= 1'b1;
			end else if (go_s1) begin
				valid_s1 <= 1'b0;
			end
			if (go_s1) begin
				valid_s2 <= 1'b1;
			end else if (s3_free) begin
				valid_s2 <= 1'b0;
			end
			if (s3_free) begin
				valid_s3 <= valid_s2;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (stk_we) begin
			stk_ba_q <= free_count_q[IDX_W-1:0];
			stk_bd_q <= idx_s1;
		end
		if (alc_we) begin
			alc_ba_q <= alc_wa_d;
			alc_bd_q <= alc_wd_d;
		end
		if (accept) begin
			cmd_s1    <= command;
			idx_s1    <= slot_index;
			stk_ra_s1 <= stk_raddr;
		end
		if (go_s1) begin
			idx_s2  <= res_idx;
			st_s2   <= res_st;
			hok_s2  <= res_hok;
			prod_s2 <= PROD_W'(res_idx) * PROD_W'(increment_q);
		end
		if (s3_free && valid_s2) begin
			idx_s3    <= idx_s2;
			st_s3     <= st_s2;
			handle_s3 <= hok_s2 ? heap_start_q + ADDR_W'(prod_s2) : '0;
		end
	end

	assign rsp_valid    = valid_s3;
	assign result_index = idx_s3;
	assign handle       = handle_s3;
	assign status       = st_s3;

	// The stack depth and the untouched pointer stay within the heap.
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		free_count_q <= CNT_W'(DEPTH))
		else $error("free stack count beyond depth");

	a_untouched_bound: assert property (@(posedge clk) disable iff (!arst_n)
		next_untouched_q > CNT_W'(SENTINEL_INDEX) && next_untouched_q <= CNT_W'(DEPTH))
		else $error("untouched pointer out of bounds");

	// The sentinel is never marked as handed out again.
	a_no_sentinel: assert property (@(posedge clk) disable iff (!arst_n)
		alc_we |-> alc_wa_d != IDX_W'(SENTINEL_INDEX))
		else $error("sentinel slot written in allocated bits");

	// The stack count changes only when an item leaves stage one.
	a_count_step: assert property (@(posedge clk) disable iff (!arst_n)
		!go_s1 |=> free_count_q == $past(free_count_q))
		else $error("free stack count changed without an item");

	// A failed item never carries a handle.
	a_err_handle: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s3 && st_s3 != ST_OK |-> handle_s3 == '0)
		else $error("handle returned with an error status");

endmodule

FILE: test/descriptor_slot_allocator_tb.sv
// ----------------------------------------------------------------------------
// Descriptor slot allocator testbench
// Runs a short table of directed requests and then random phases, each under
// its own capacity, heap base and increment setting. The request and response
// handshakes idle at random outside the quiet phases. Every response is compared
// with its table entry or with a cycle-free model of the free stack, bump pointer
// and allocated bits that is kept in step with the requests the block accepts.
// ----------------------------------------------------------------------------
module descriptor_slot_allocator_tb
	import dsa_pkg::*;
();

	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [1:0] CMD_UNUSED = 2'd3;
	localparam int PHASES = 8;
	localparam int ITEMS_PER_PHASE = 225;
	localparam int TAIL_CYCLES = 8;
	localparam int TIMEOUT_NS = 2_000_000;

	typedef struct packed {
		logic [IDX_W-1:0]  idx;
		logic [ADDR_W-1:0] hnd;
		status_t           st;
	} slot_result_t;

	typedef struct {
		bit                is_setting;
		logic [1:0]        cmd;
		logic [IDX_W-1:0]  idx;
		bit                typed;
		slot_result_t      want;
		logic [CNT_W-1:0]  cap;
		logic [ADDR_W-1:0] base;
		logic [INC_W-1:0]  stride;
	} plan_row_t;

	logic                 clk = 1'b0;
	logic                 arst_n;
	logic                 req_valid;
	logic                 req_stall;
	logic [1:0]           command;
	logic [IDX_W-1:0]     slot_index;
	logic                 rsp_valid;
	logic                 rsp_stall = 1'b0;
	logic [IDX_W-1:0]     result_index;
	logic [ADDR_W-1:0]    handle;
	logic [2:0]           status;
	logic                 cfg_valid;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [ADDR_W-1:0]    cfg_data;

	// Model of the allocator state and its registers.
	logic [IDX_W-1:0]  free_lifo [DEPTH];
	int unsigned       lifo_depth;
	int unsigned       bump_next;
	bit                in_use [DEPTH];
	logic [CNT_W-1:0]  cfg_capacity;
	logic [ADDR_W-1:0] cfg_heap_start;
	logic [INC_W-1:0]  cfg_increment;

	slot_result_t pending_results[$];
	plan_row_t    plan[$];
	bit           quiet_phase;
	int unsigned  errors;
	int unsigned  requests_sent;
	int unsigned  responses_seen;
	int unsigned  settings_done;
	int unsigned  status_seen [8];
	int unsigned  stall_left;

	descriptor_slot_allocator dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.req_valid    (req_valid),
		.req_stall    (req_stall),
		.command      (command),
		.slot_index   (slot_index),
		.rsp_valid    (rsp_valid),
		.rsp_stall    (rsp_stall),
		.result_index (result_index),
		.handle       (handle),
		.status       (status),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	function automatic logic [ADDR_W-1:0] slot_address(logic [IDX_W-1:0] idx);
		return cfg_heap_start + ADDR_W'(idx) * ADDR_W'(cfg_increment);
	endfunction

	function automatic slot_result_t predict_slot(logic [1:0] cmd, logic [IDX_W-1:0] idx);
		slot_result_t     r;
		int unsigned      limit;
		logic [IDX_W-1:0] got;
		limit = (cfg_capacity > DEPTH) ? DEPTH : cfg_capacity;
		r = '{idx: idx, hnd: '0, st: ST_RANGE};
		case (cmd)
			CMD_ALLOC: begin
				if (lifo_depth != 0) begin
					lifo_depth--;
					got = free_lifo[lifo_depth];
				end else if (bump_next < limit) begin
					got = IDX_W'(bump_next);
					bump_next++;
				end else begin
					return '{idx: '0, hnd: '0, st: ST_FULL};
				end
				in_use[got] = 1'b1;
				r = '{idx: got, hnd: slot_address(got), st: ST_OK};
			end
			CMD_FREE: begin
				if (idx >= limit)
					r.st = ST_RANGE;
				else if (idx == SENTINEL_INDEX)
					r.st = ST_SENTINEL;
				else if (!in_use[idx])
					r.st = ST_NOTALLOC;
				else begin
					in_use[idx] = 1'b0;
					if (lifo_depth < DEPTH) begin
						free_lifo[lifo_depth] = idx;
						lifo_depth++;
					end
					r.st = ST_OK;
				end
			end
			CMD_GET: begin
				if (idx < limit)
					r = '{idx: idx, hnd: slot_address(idx), st: ST_OK};
			end
			default: r.st = ST_RANGE;
		endcase
		return r;
	endfunction

	function automatic void plan_item(logic [1:0] cmd, logic [IDX_W-1:0] idx);
		plan_row_t row;
		row = '{default: '0};
		row.cmd = cmd;
		row.idx = idx;
		plan.insert(plan.size(), row);
	endfunction

	function automatic void plan_typed(logic [1:0] cmd, logic [IDX_W-1:0] idx,
			logic [IDX_W-1:0] ridx, logic [ADDR_W-1:0] hnd, status_t st);
		plan_row_t row;
		row = '{default: '0};
		row.cmd = cmd;
		row.idx = idx;
		row.typed = 1'b1;
		row.want = '{idx: ridx, hnd: hnd, st: st};
		plan.insert(plan.size(), row);
	endfunction

	function automatic void plan_setting(logic [CNT_W-1:0] cap, logic [ADDR_W-1:0] base,
			logic [INC_W-1:0] stride);
		plan_row_t row;
		row = '{default: '0};
		row.is_setting = 1'b1;
		row.cap = cap;
		row.base = base;
		row.stride = stride;
		plan.insert(plan.size(), row);
	endfunction

	// Called at the step of the last accepted request, or later.
	task automatic program_heap(input logic [CNT_W-1:0] cap, input logic [ADDR_W-1:0] base,
			input logic [INC_W-1:0] stride);
		logic [CFG_IDX_W-1:0] regs [3];
		logic [ADDR_W-1:0]    words [3];
		req_valid <= 1'b0;
		regs = '{REG_CAPACITY, REG_HEAP_START, REG_INCREMENT};
		// Upper bits of the narrow registers carry noise that must be dropped.
		words[0] = {$urandom(), $urandom()};
		words[0][CNT_W-1:0] = cap;
		words[1] = base;
		words[2] = {$urandom(), $urandom()};
		words[2][INC_W-1:0] = stride;
		// Wait on the falling edge so the response checker has finished its pop.
		do @(negedge clk); while (pending_results.size() != 0);
		@(posedge clk);
		cfg_valid <= 1'b1;
		for (int k = 0; k < 3; k++) begin
			cfg_index <= regs[k];
			cfg_data <= words[k];
			do @(posedge clk); while (!cfg_ready);
			case (regs[k])
				REG_CAPACITY:   cfg_capacity = words[k][CNT_W-1:0];
				REG_HEAP_START: cfg_heap_start = words[k];
				default:        cfg_increment = words[k][INC_W-1:0];
			endcase
		end
		cfg_valid <= 1'b0;
		settings_done++;
	endtask

	// Leaves req_valid high after the beat; the next call or the caller lowers it.
	task automatic send_request(input logic [1:0] cmd, input logic [IDX_W-1:0] idx,
			input bit typed, input slot_result_t want);
		int unsigned  gap;
		slot_result_t predicted;
		gap = quiet_phase ? 0 : $urandom_range(0, 3);
		if (gap != 0) begin
			req_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_valid <= 1'b1;
		command <= cmd;
		slot_index <= idx;
		do @(posedge clk); while (req_stall);
		predicted = predict_slot(cmd, idx);
		pending_results.insert(pending_results.size(), typed ? want : predicted);
		requests_sent++;
	endtask

	// Receiver: after each accepted response, may hold off at random, except in quiet phases.
	always @(posedge clk) begin
		if (!arst_n) begin
			rsp_stall <= 1'b0;
			stall_left <= 0;
		end else if (rsp_valid && !rsp_stall) begin : draw_stall
			int unsigned n;
			n = quiet_phase ? 0 : $urandom_range(0, 3);
			stall_left <= n;
			rsp_stall <= (n != 0);
		end else if (stall_left > 1) begin
			stall_left <= stall_left - 1;
		end else begin
			stall_left <= 0;
			rsp_stall <= 1'b0;
		end
	end

	always @(posedge clk) begin : rsp_check
		slot_result_t want;
		if (arst_n && rsp_valid && !rsp_stall) begin
			responses_seen++;
			status_seen[status]++;
			if (pending_results.size() == 0) begin
				errors++;
				$display("%0t: response with nothing outstanding: index %0d handle %h status %0d",
					$time, result_index, handle, status);
			end else begin
				want = pending_results.pop_front();
				if (result_index !== want.idx) begin
					errors++;
					$display("%0t: result_index expected %0d, got %0d",
						$time, want.idx, result_index);
				end
				if (handle !== want.hnd) begin
					errors++;
					$display("%0t: handle expected %h, got %h", $time, want.hnd, handle);
				end
				if (status !== want.st) begin
					errors++;
					$display("%0t: status expected %0d, got %0d", $time, want.st, status);
				end
			end
		end
	end

	initial begin
		#(TIMEOUT_NS);
		$display("Timeout with %0d responses outstanding", pending_results.size());
		$display("CHECKS FAILED");
		$finish;
	end

	initial begin
		logic [1:0]        cmd;
		logic [IDX_W-1:0]  idx;
		logic [CNT_W-1:0]  cap;
		logic [ADDR_W-1:0] base;
		logic [INC_W-1:0]  stride;
		int unsigned       alloc_pct;
		int unsigned       r;

		arst_n <= 1'b0;
		req_valid <= 1'b0;
		command <= CMD_ALLOC;
		slot_index <= '0;
		cfg_valid <= 1'b0;
		cfg_index <= REG_CAPACITY;
		cfg_data <= '0;
		quiet_phase = 1'b0;
		errors = 0;
		requests_sent = 0;
		responses_seen = 0;
		settings_done = 0;
		foreach (status_seen[i]) status_seen[i] = 0;
		foreach (free_lifo[i]) free_lifo[i] = '0;
		foreach (in_use[i]) in_use[i] = 1'b0;
		in_use[SENTINEL_INDEX] = 1'b1;
		lifo_depth = 0;
		bump_next = SENTINEL_INDEX + 1;
		cfg_capacity = CAPACITY_RST;
		cfg_heap_start = '0;
		cfg_increment = INCREMENT_RST;

		// Reset values: capacity 1024, base 0, increment 32.
		plan_typed(CMD_ALLOC, 10'd0, 10'd1, 64'd32, ST_OK);
		plan_typed(CMD_ALLOC, 10'd1023, 10'd2, 64'd64, ST_OK);
		plan_typed(CMD_FREE, 10'd0, 10'd0, 64'd0, ST_SENTINEL);
		plan_typed(CMD_FREE, 10'd1023, 10'd1023, 64'd0, ST_NOTALLOC);
		plan_typed(CMD_GET, 10'd1023, 10'd1023, 64'd32736, ST_OK);
		plan_typed(CMD_GET, 10'd0, 10'd0, 64'd0, ST_OK);
		plan_typed(CMD_UNUSED, 10'd1023, 10'd1023, 64'd0, ST_RANGE);
		plan_typed(CMD_FREE, 10'd1, 10'd1, 64'd0, ST_OK);
		plan_typed(CMD_FREE, 10'd1, 10'd1, 64'd0, ST_NOTALLOC);
		plan_item(CMD_FREE, 10'd2);
		plan_item(CMD_ALLOC, 10'd0);
		plan_item(CMD_ALLOC, 10'd0);
		plan_item(CMD_ALLOC, 10'd0);
		// Capacity lowered below the bump pointer.
		plan_setting(11'd3, '1, 12'hFFF);
		plan_typed(CMD_ALLOC, 10'd0, 10'd0, 64'd0, ST_FULL);
		plan_typed(CMD_FREE, 10'd3, 10'd3, 64'd0, ST_RANGE);
		plan_item(CMD_FREE, 10'd2);
		plan_item(CMD_GET, 10'd2);
		plan_item(CMD_GET, 10'd1);
		// A stacked index is still handed out under a capacity of one.
		plan_setting(11'd1, '0, 12'd0);
		plan_item(CMD_ALLOC, 10'd0);
		plan_typed(CMD_ALLOC, 10'd0, 10'd0, 64'd0, ST_FULL);
		plan_typed(CMD_FREE, 10'd0, 10'd0, 64'd0, ST_SENTINEL);
		plan_typed(CMD_FREE, 10'd1, 10'd1, 64'd0, ST_RANGE);
		// With capacity zero the range check wins over the sentinel check.
		plan_setting(11'd0, 64'h8000_0000_0000_0000, 12'd1);
		plan_typed(CMD_FREE, 10'd0, 10'd0, 64'd0, ST_RANGE);
		plan_typed(CMD_GET, 10'd0, 10'd0, 64'd0, ST_RANGE);
		// Capacity above the heap depth is clipped.
		plan_setting(11'h7FF, '0, 12'hFFF);
		plan_item(CMD_GET, 10'd1023);
		plan_typed(CMD_FREE, 10'd1023, 10'd1023, 64'd0, ST_NOTALLOC);
		plan_item(CMD_ALLOC, 10'd0);

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		foreach (plan[i]) begin
			if (plan[i].is_setting)
				program_heap(plan[i].cap, plan[i].base, plan[i].stride);
			else
				send_request(plan[i].cmd, plan[i].idx, plan[i].typed, plan[i].want);
		end

		for (int p = 0; p < PHASES; p++) begin
			base = {$urandom(), $urandom()};
			stride = INC_W'($urandom());
			case (p)
				0: begin
					cap = 11'd1024;
					stride = 12'hFFF;
					alloc_pct = 70;
				end
				1: begin
					cap = 11'd2;
					base = '1;
					alloc_pct = 50;
				end
				2: begin
					cap = CNT_W'($urandom_range(2, 40));
					alloc_pct = 50;
				end
				3: begin
					cap = 11'h7FF;
					base = '0;
					stride = '0;
					alloc_pct = 85;
				end
				4: begin
					cap = CNT_W'($urandom_range(0, 1));
					alloc_pct = 40;
				end
				5: begin
					cap = CNT_W'($urandom());
					alloc_pct = 50;
				end
				6: begin
					cap = 11'd1024;
					base = '1;
					stride = 12'hFFF;
					alloc_pct = 60;
				end
				default: begin
					cap = CNT_W'($urandom_range(2, 1024));
					alloc_pct = 45;
				end
			endcase
			program_heap(cap, base, stride);
			quiet_phase = (p == 2 || p == 6);
			for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
				r = $urandom_range(0, 99);
				idx = IDX_W'($urandom());
				if (r < alloc_pct) begin
					cmd = CMD_ALLOC;
				end else if (r < alloc_pct + (100 - alloc_pct) * 6 / 10) begin
					cmd = CMD_FREE;
					// Most frees target an index that has been handed out.
					if (bump_next > 1 && $urandom_range(0, 3) != 0)
						idx = IDX_W'($urandom_range(1, bump_next - 1));
				end else if (r < 97) begin
					cmd = CMD_GET;
				end else begin
					cmd = CMD_UNUSED;
				end
				send_request(cmd, idx, 1'b0, '0);
			end
		end

		req_valid <= 1'b0;
		while (pending_results.size() != 0) @(negedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);

		$display("Run covered %0d requests under %0d register settings, %0d responses compared",
			requests_sent, settings_done, responses_seen);
		$display("Statuses: ok %0d, heap full %0d, out of range %0d, not allocated %0d, sentinel %0d",
			status_seen[ST_OK], status_seen[ST_FULL], status_seen[ST_RANGE],
			status_seen[ST_NOTALLOC], status_seen[ST_SENTINEL]);
		if (errors == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule
